// ===== rtl/tet_pkg.sv =====
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types, token codes and character classes for the template
// expression tokenizer.
// ----------------------------------------------------------------------------
package tet_pkg;

    // Lexing phases. The eight pending two-character operators follow
    // PH_PEND0 in the order of the pending table below.
    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_WS     = 5'd1,
        PH_TEXT   = 5'd2,
        PH_INT    = 5'd3,
        PH_INTDOT = 5'd4,
        PH_FRAC   = 5'd5,
        PH_IDENT  = 5'd6,
        PH_STR    = 5'd7,
        PH_STRESC = 5'd8,
        PH_PEND0  = 5'd9,
        PH_PEND1  = 5'd10,
        PH_PEND2  = 5'd11,
        PH_PEND3  = 5'd12,
        PH_PEND4  = 5'd13,
        PH_PEND5  = 5'd14,
        PH_PEND6  = 5'd15,
        PH_PEND7  = 5'd16,
        PH_ERR    = 5'd17
    } t_phase;

    // Token kinds.
    localparam logic [5:0] TK_SEGMENT  = 6'd0;
    localparam logic [5:0] TK_LBRACE   = 6'd1;
    localparam logic [5:0] TK_RBRACE   = 6'd2;
    localparam logic [5:0] TK_LPAREN   = 6'd3;
    localparam logic [5:0] TK_RPAREN   = 6'd4;
    localparam logic [5:0] TK_LBRACKET = 6'd5;
    localparam logic [5:0] TK_RBRACKET = 6'd6;
    localparam logic [5:0] TK_PLUS     = 6'd7;
    localparam logic [5:0] TK_MINUS    = 6'd8;
    localparam logic [5:0] TK_STAR     = 6'd9;
    localparam logic [5:0] TK_SLASH    = 6'd10;
    localparam logic [5:0] TK_PERCENT  = 6'd11;
    localparam logic [5:0] TK_CARET    = 6'd12;
    localparam logic [5:0] TK_DOLLAR   = 6'd13;
    localparam logic [5:0] TK_DOT      = 6'd14;
    localparam logic [5:0] TK_COMMA    = 6'd15;
    localparam logic [5:0] TK_QUESTION = 6'd16;
    localparam logic [5:0] TK_COALESCE = 6'd17;
    localparam logic [5:0] TK_COLON    = 6'd18;
    localparam logic [5:0] TK_ASSIGN   = 6'd19;
    localparam logic [5:0] TK_LESS     = 6'd20;
    localparam logic [5:0] TK_LESS_EQ  = 6'd21;
    localparam logic [5:0] TK_GREATER  = 6'd22;
    localparam logic [5:0] TK_GREAT_EQ = 6'd23;
    localparam logic [5:0] TK_EQ_EQ    = 6'd24;
    localparam logic [5:0] TK_NOT      = 6'd25;
    localparam logic [5:0] TK_NOT_EQ   = 6'd26;
    localparam logic [5:0] TK_AND      = 6'd27;
    localparam logic [5:0] TK_OR       = 6'd28;
    localparam logic [5:0] TK_INTEGER  = 6'd29;
    localparam logic [5:0] TK_FLOAT    = 6'd30;
    localparam logic [5:0] TK_IDENT    = 6'd31;
    localparam logic [5:0] TK_STRING   = 6'd32;
    localparam logic [5:0] TK_EOF      = 6'd33;
    localparam logic [5:0] TK_ERROR    = 6'd34;

    // Error causes.
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_EQUAL     = 4'd1;
    localparam logic [3:0] ERR_AMP       = 4'd2;
    localparam logic [3:0] ERR_PIPE      = 4'd3;
    localparam logic [3:0] ERR_RBRACE    = 4'd4;
    localparam logic [3:0] ERR_UNKNOWN   = 4'd5;
    localparam logic [3:0] ERR_EOS_STR   = 4'd6;
    localparam logic [3:0] ERR_EOS_EXPR  = 4'd7;
    localparam logic [3:0] ERR_TOO_LONG  = 4'd8;

    // Input kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // One result item.
    typedef struct packed {
        logic [3:0]  err;
        logic [15:0] tok_end;
        logic [15:0] tok_start;
        logic [5:0]  kind;
    } t_tok;

    // Match against the pending-operator table.
    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_pend;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    // First characters of operators that may take a second character.
    function automatic t_pend pend_lookup(input logic [7:0] c);
        t_pend p;
        p.hit = 1'b1;
        p.idx = 3'd0;
        case (c)
            "?": p.idx = 3'd0;
            ":": p.idx = 3'd1;
            "<": p.idx = 3'd2;
            ">": p.idx = 3'd3;
            "=": p.idx = 3'd4;
            "!": p.idx = 3'd5;
            "&": p.idx = 3'd6;
            "|": p.idx = 3'd7;
            default: p.hit = 1'b0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] pend_second(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0: c = "?";
            3'd6: c = "&";
            3'd7: c = "|";
            default: c = "=";
        endcase
        return c;
    endfunction

    function automatic logic [5:0] pend_single(input logic [2:0] i);
        logic [5:0] k;
        case (i)
            3'd0: k = TK_QUESTION;
            3'd1: k = TK_COLON;
            3'd2: k = TK_LESS;
            3'd3: k = TK_GREATER;
            3'd5: k = TK_NOT;
            default: k = TK_SEGMENT;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pend_double(input logic [2:0] i);
        logic [5:0] k;
        case (i)
            3'd0: k = TK_COALESCE;
            3'd1: k = TK_ASSIGN;
            3'd2: k = TK_LESS_EQ;
            3'd3: k = TK_GREAT_EQ;
            3'd4: k = TK_EQ_EQ;
            3'd5: k = TK_NOT_EQ;
            3'd6: k = TK_AND;
            default: k = TK_OR;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] pend_err(input logic [2:0] i);
        logic [3:0] e;
        case (i)
            3'd4: e = ERR_EQUAL;
            3'd6: e = ERR_AMP;
            3'd7: e = ERR_PIPE;
            default: e = ERR_NONE;
        endcase
        return e;
    endfunction

    // Single-character operators; TK_SEGMENT means none.
    function automatic logic [5:0] op_single(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "(": k = TK_LPAREN;
            ")": k = TK_RPAREN;
            "[": k = TK_LBRACKET;
            "]": k = TK_RBRACKET;
            "+": k = TK_PLUS;
            "-": k = TK_MINUS;
            "*": k = TK_STAR;
            "/": k = TK_SLASH;
            "%": k = TK_PERCENT;
            "^": k = TK_CARET;
            "$": k = TK_DOLLAR;
            ".": k = TK_DOT;
            ",": k = TK_COMMA;
            default: k = TK_SEGMENT;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/template_expression_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// template_expression_tokenizer_top
// Template tokenizer: source bytes in, tokens with kind and offsets out.
//
//   Channel  | Direction | Carries
//   ---------+-----------+-------------------------------------------------
//   s        | in        | tuser: kind; tdata: char_byte
//   m        | out       | tdata: token_kind, token_start, token_end,
//            |           |        error_code; tlast: last
//   cfg      | in        | direct_mode, written when i_cfg_we is high
//
// An item is lexed in the cycle it is accepted and its tokens land in a
// three-entry result register. A new item is taken every cycle while each item
// gives at most one token and the output is not stalled; an item that gives
// more holds the input off until only its last token is left and being taken.
// Reset is synchronous and clears the lexer state and the result count. A
// stalled output holds the input off once its last pending token is not taken.
// ----------------------------------------------------------------------------
module template_expression_tokenizer_top #(
    parameter int OFFSET_BITS = 16,
    parameter int MAX_DEPTH   = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,   // direct_mode
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] char_byte
    input  logic        i_s_tuser,     // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,     // [5:0] token_kind, [21:6] token_start,
                                       // [37:22] token_end, [41:38] error_code
    output logic        o_m_tlast      // last
);
    import tet_pkg::*;

    localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);

    // Lexer state.
    t_phase                  r_phase, n_phase;
    logic [OFFSET_BITS-1:0]  r_off, n_off;
    logic [DEPTH_BITS-1:0]   r_depth, n_depth;
    logic [OFFSET_BITS-1:0]  r_start, n_start;
    logic                    r_quote, n_quote;
    logic                    r_direct;

    // Result register.
    t_tok        r_tok [3];
    logic [2:0]  r_last;
    logic [1:0]  r_cnt;
    t_tok        lx_tok [3];
    logic [1:0]  lx_cnt;
    logic        s_xfer, m_xfer;

    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign m_xfer     = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_m_tready);
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = {6'd0, r_tok[0]};
    assign o_m_tlast  = r_last[0];

    tet_lex #(
        .OFFSET_BITS (OFFSET_BITS),
        .MAX_DEPTH   (MAX_DEPTH),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_lex (
        .i_direct (r_direct),
        .i_eos    (i_s_tuser == KIND_END),
        .i_char   (i_s_tdata),
        .i_phase  (r_phase),
        .i_off    (r_off),
        .i_depth  (r_depth),
        .i_start  (r_start),
        .i_quote  (r_quote),
        .o_phase  (n_phase),
        .o_off    (n_off),
        .o_depth  (n_depth),
        .o_start  (n_start),
        .o_quote  (n_quote),
        .o_tok    (lx_tok),
        .o_cnt    (lx_cnt)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct <= 1'b0;
        end else if (i_cfg_we) begin
            r_direct <= i_cfg_wdata;
        end
    end

    // Lexer state advances on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_off   <= '0;
            r_depth <= '0;
            r_start <= '0;
            r_quote <= 1'b0;
        end else if (s_xfer) begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_depth <= n_depth;
            r_start <= n_start;
            r_quote <= n_quote;
        end
    end

    // Result register: loaded on an input transfer, shifted on an output one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_last <= 3'd0;
        end else if (s_xfer) begin
            r_cnt  <= lx_cnt;
            r_last <= {lx_cnt == 2'd3, lx_cnt == 2'd2, lx_cnt == 2'd1};
        end else if (m_xfer) begin
            r_cnt  <= r_cnt - 2'd1;
            r_last <= {1'b0, r_last[2:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_tok[0] <= lx_tok[0];
            r_tok[1] <= lx_tok[1];
            r_tok[2] <= lx_tok[2];
        end else if (m_xfer) begin
            r_tok[0] <= r_tok[1];
            r_tok[1] <= r_tok[2];
        end
    end

endmodule

// ===== rtl/tet_lex.sv =====
// ----------------------------------------------------------------------------
// tet_lex
// Next-state and token logic: from the lexer state and one input item it
// works out the new state and up to three result tokens.
// ----------------------------------------------------------------------------
module tet_lex #(
    parameter int OFFSET_BITS = 16,
    parameter int MAX_DEPTH   = 255,
    parameter int DEPTH_BITS  = 8
) (
    input  logic                    i_direct,
    input  logic                    i_eos,
    input  logic [7:0]              i_char,
    input  tet_pkg::t_phase         i_phase,
    input  logic [OFFSET_BITS-1:0]  i_off,
    input  logic [DEPTH_BITS-1:0]   i_depth,
    input  logic [OFFSET_BITS-1:0]  i_start,
    input  logic                    i_quote,
    output tet_pkg::t_phase         o_phase,
    output logic [OFFSET_BITS-1:0]  o_off,
    output logic [DEPTH_BITS-1:0]   o_depth,
    output logic [OFFSET_BITS-1:0]  o_start,
    output logic                    o_quote,
    output tet_pkg::t_tok           o_tok [3],
    output logic [1:0]              o_cnt
);
    import tet_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OffOne = OFFSET_BITS'(1);
    localparam logic [DEPTH_BITS-1:0]  DepthMax = DEPTH_BITS'(MAX_DEPTH);

    function automatic t_tok mk(input logic [5:0] k, input logic [OFFSET_BITS-1:0] s,
                                input logic [OFFSET_BITS-1:0] e, input logic [3:0] er);
        logic [OFFSET_BITS+15:0] ws;
        logic [OFFSET_BITS+15:0] we;
        t_tok t;
        ws = {16'd0, s};
        we = {16'd0, e};
        t.kind      = k;
        t.tok_start = ws[15:0];
        t.tok_end   = we[15:0];
        t.err       = er;
        return t;
    endfunction

    // Reaction to a byte that starts a new token.
    t_phase                  id_phase;
    logic [OFFSET_BITS-1:0]  id_start;
    logic [DEPTH_BITS-1:0]   id_depth;
    logic                    id_quote;
    logic                    id_emit;
    t_tok                    id_tok;
    t_pend                   id_pend;
    logic [5:0]              id_op;

    always_comb begin
        id_phase = PH_IDLE;
        id_start = i_off;
        id_depth = i_depth;
        id_quote = i_quote;
        id_emit  = 1'b0;
        id_tok   = mk(TK_SEGMENT, i_off, i_off, ERR_NONE);
        id_pend  = pend_lookup(i_char);
        id_op    = op_single(i_char);
        if (i_direct || (i_depth != '0)) begin
            if (is_space(i_char)) begin
                id_phase = PH_WS;
            end else if (is_digit(i_char)) begin
                id_phase = PH_INT;
            end else if (is_alpha(i_char) || (i_char == "_")) begin
                id_phase = PH_IDENT;
            end else if ((i_char == "'") || (i_char == "\"")) begin
                id_quote = (i_char == "\"");
                id_start = i_off + OffOne;
                id_phase = PH_STR;
            end else if (id_pend.hit) begin
                id_phase = t_phase'(5'(PH_PEND0) + {2'b00, id_pend.idx});
            end else if (i_char == "{") begin
                id_emit = 1'b1;
                id_tok  = mk(TK_LBRACE, i_off, i_off + OffOne, ERR_NONE);
                if (i_depth < DepthMax) begin
                    id_depth = i_depth + 1'b1;
                end
            end else if (i_char == "}") begin
                id_emit = 1'b1;
                if (i_depth == '0) begin
                    id_tok   = mk(TK_ERROR, i_off, i_off + OffOne, ERR_RBRACE);
                    id_phase = PH_ERR;
                end else begin
                    id_tok   = mk(TK_RBRACE, i_off, i_off + OffOne, ERR_NONE);
                    id_depth = i_depth - 1'b1;
                end
            end else if (id_op != TK_SEGMENT) begin
                id_emit = 1'b1;
                id_tok  = mk(id_op, i_off, i_off + OffOne, ERR_NONE);
            end else begin
                id_emit  = 1'b1;
                id_tok   = mk(TK_ERROR, i_off, i_off + OffOne, ERR_UNKNOWN);
                id_phase = PH_ERR;
            end
        end else if (i_char == "{") begin
            id_emit = 1'b1;
            id_tok  = mk(TK_LBRACE, i_off, i_off + OffOne, ERR_NONE);
            id_start = i_start;
            if (i_depth < DepthMax) begin
                id_depth = i_depth + 1'b1;
            end
        end else begin
            id_phase = PH_TEXT;
        end
    end

    // Main step: flush of a pending token, then the new byte or the end item.
    logic [2:0]  pidx;
    logic [7:0]  qchar;

    always_comb begin
        o_phase = i_phase;
        o_off   = i_off;
        o_depth = i_depth;
        o_start = i_start;
        o_quote = i_quote;
        o_cnt   = 2'd0;
        for (int k = 0; k < 3; k++) begin
            o_tok[k] = mk(TK_SEGMENT, i_off, i_off, ERR_NONE);
        end
        pidx  = 3'(5'(i_phase) - 5'(PH_PEND0));
        qchar = i_quote ? "\"" : "'";

        if (i_eos) begin
            o_phase = PH_IDLE;
            o_off   = '0;
            o_depth = '0;
            o_start = '0;
            o_quote = 1'b0;
            if (i_phase == PH_ERR) begin
                o_cnt = 2'd0;
            end else if ((i_phase == PH_STR) || (i_phase == PH_STRESC)) begin
                o_tok[0] = mk(TK_ERROR, i_off - OffOne, i_off, ERR_EOS_STR);
                o_cnt    = 2'd1;
            end else if ((i_phase == PH_WS) && !i_direct) begin
                o_tok[0] = mk(TK_ERROR, i_off - OffOne, i_off, ERR_EOS_EXPR);
                o_cnt    = 2'd1;
            end else begin
                case (i_phase)
                    PH_TEXT: begin
                        o_tok[0] = mk(TK_SEGMENT, i_start, i_off, ERR_NONE);
                        o_cnt    = 2'd1;
                    end
                    PH_INT: begin
                        o_tok[0] = mk(TK_INTEGER, i_start, i_off, ERR_NONE);
                        o_cnt    = 2'd1;
                    end
                    PH_FRAC: begin
                        o_tok[0] = mk(TK_FLOAT, i_start, i_off, ERR_NONE);
                        o_cnt    = 2'd1;
                    end
                    PH_IDENT: begin
                        o_tok[0] = mk(TK_IDENT, i_start, i_off, ERR_NONE);
                        o_cnt    = 2'd1;
                    end
                    PH_INTDOT: begin
                        o_tok[0] = mk(TK_INTEGER, i_start, i_off - OffOne, ERR_NONE);
                        o_tok[1] = mk(TK_DOT, i_off - OffOne, i_off, ERR_NONE);
                        o_cnt    = 2'd2;
                    end
                    PH_PEND0, PH_PEND1, PH_PEND2, PH_PEND3,
                    PH_PEND4, PH_PEND5, PH_PEND6, PH_PEND7: begin
                        if (pend_err(pidx) != ERR_NONE) begin
                            o_tok[0] = mk(TK_ERROR, i_start, i_start + OffOne,
                                          pend_err(pidx));
                        end else begin
                            o_tok[0] = mk(pend_single(pidx), i_start, i_start + OffOne,
                                          ERR_NONE);
                        end
                        o_cnt = 2'd1;
                    end
                    default: o_cnt = 2'd0;
                endcase
                // End of file follows unless the flush raised an error.
                if (!((o_cnt == 2'd1) && (o_tok[0].kind == TK_ERROR))) begin
                    o_tok[o_cnt] = mk(TK_EOF, i_off, i_off, ERR_NONE);
                    o_cnt        = o_cnt + 2'd1;
                end
            end
        end else if (i_phase != PH_ERR) begin
            if (i_off == '1) begin
                o_tok[0] = mk(TK_ERROR, i_off, i_off, ERR_TOO_LONG);
                o_cnt    = 2'd1;
                o_phase  = PH_ERR;
            end else begin
                o_off = i_off + OffOne;
                case (i_phase)
                    PH_IDLE, PH_WS: begin
                        o_phase = id_phase;
                        o_start = id_start;
                        o_depth = id_depth;
                        o_quote = id_quote;
                        if (id_emit) begin
                            o_tok[0] = id_tok;
                            o_cnt    = 2'd1;
                        end
                    end
                    PH_TEXT: begin
                        if (i_char == "{") begin
                            o_tok[0] = mk(TK_SEGMENT, i_start, i_off, ERR_NONE);
                            o_tok[1] = id_tok;
                            o_cnt    = 2'd2;
                            o_phase  = PH_IDLE;
                            o_depth  = id_depth;
                        end
                    end
                    PH_STR: begin
                        if (i_char == "\\") begin
                            o_phase = PH_STRESC;
                        end else if (i_char == qchar) begin
                            o_tok[0] = mk(TK_STRING, i_start, i_off, ERR_NONE);
                            o_cnt    = 2'd1;
                            o_phase  = PH_IDLE;
                        end
                    end
                    PH_STRESC: begin
                        o_phase = PH_STR;
                    end
                    PH_INT, PH_FRAC, PH_IDENT: begin
                        if (((i_phase == PH_IDENT) && is_word(i_char)) ||
                            ((i_phase != PH_IDENT) && is_digit(i_char))) begin
                            o_phase = i_phase;
                        end else if ((i_phase == PH_INT) && (i_char == ".")) begin
                            o_phase = PH_INTDOT;
                        end else begin
                            o_tok[0] = mk((i_phase == PH_INT) ? TK_INTEGER :
                                          (i_phase == PH_FRAC) ? TK_FLOAT : TK_IDENT,
                                          i_start, i_off, ERR_NONE);
                            o_tok[1] = id_tok;
                            o_cnt    = id_emit ? 2'd2 : 2'd1;
                            o_phase  = id_phase;
                            o_start  = id_start;
                            o_depth  = id_depth;
                            o_quote  = id_quote;
                        end
                    end
                    PH_INTDOT: begin
                        if (is_digit(i_char)) begin
                            o_phase = PH_FRAC;
                        end else begin
                            o_tok[0] = mk(TK_INTEGER, i_start, i_off - OffOne, ERR_NONE);
                            o_tok[1] = mk(TK_DOT, i_off - OffOne, i_off, ERR_NONE);
                            o_tok[2] = id_tok;
                            o_cnt    = id_emit ? 2'd3 : 2'd2;
                            o_phase  = id_phase;
                            o_start  = id_start;
                            o_depth  = id_depth;
                            o_quote  = id_quote;
                        end
                    end
                    PH_PEND0, PH_PEND1, PH_PEND2, PH_PEND3,
                    PH_PEND4, PH_PEND5, PH_PEND6, PH_PEND7: begin
                        if (i_char == pend_second(pidx)) begin
                            o_tok[0] = mk(pend_double(pidx), i_start, i_off + OffOne,
                                          ERR_NONE);
                            o_cnt    = 2'd1;
                            o_phase  = PH_IDLE;
                        end else if (pend_err(pidx) != ERR_NONE) begin
                            o_tok[0] = mk(TK_ERROR, i_start, i_start + OffOne,
                                          pend_err(pidx));
                            o_cnt    = 2'd1;
                            o_phase  = PH_ERR;
                        end else begin
                            o_tok[0] = mk(pend_single(pidx), i_start, i_start + OffOne,
                                          ERR_NONE);
                            o_tok[1] = id_tok;
                            o_cnt    = id_emit ? 2'd2 : 2'd1;
                            o_phase  = id_phase;
                            o_start  = id_start;
                            o_depth  = id_depth;
                            o_quote  = id_quote;
                        end
                    end
                    default: o_phase = i_phase;
                endcase
            end
        end
    end

endmodule

// ===== rtl/tet_checker.sv =====
// ----------------------------------------------------------------------------
// tet_checker
// Port-level checks on the tokenizer's handshakes and token bursts.
// ----------------------------------------------------------------------------
module tet_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tlast
);
    import tet_pkg::*;

    // A stalled token stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled token changed");

    // A burst that is not finished keeps going after a transfer.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("token burst broken");

    // No new item while more than one token is still owed.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input taken during burst");

    // Only an error token carries an error cause.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[41:38] != ERR_NONE) |-> (o_m_tdata[5:0] == TK_ERROR))
        else $error("error cause on a plain token");

endmodule

bind template_expression_tokenizer_top tet_checker u_tet_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ===== bench/template_expression_tokenizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// Template expression tokenizer testbench
// Streams template sources through the tokenizer under random idling on both
// sides. A behavioural lexer in the bench predicts every token, and each
// output transfer is checked against the oldest predicted token.
// ----------------------------------------------------------------------------
module template_expression_tokenizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tet_pkg::*;

    localparam int OFF_MASK = 16'hFFFF;
    localparam int DEPTH_CAP = 255;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } t_src;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] tok_start;
        logic [15:0] tok_end;
        logic [3:0]  err;
        logic        last;
    } t_exp_tok;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic        o_m_tlast;

    template_expression_tokenizer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Lexer state held by the predictor.
    logic        lx_direct;
    logic [15:0] lx_offset;
    logic [7:0]  lx_depth;
    t_phase      lx_phase;
    logic [15:0] lx_start;
    logic        lx_dq;

    t_src     pending_src[$];
    t_exp_tok expected_toks[$];
    t_exp_tok step_toks[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    logic     drv_enable = 1'b0;

    function automatic void push_tok(logic [5:0] k, logic [15:0] s, logic [15:0] e,
                                     logic [3:0] er);
        t_exp_tok t;
        t.kind = k;
        t.tok_start = s;
        t.tok_end = e;
        t.err = er;
        t.last = 1'b0;
        if (step_toks.size() < 3) step_toks.push_back(t);
    endfunction

    function automatic void raise_err(logic [3:0] code, logic [15:0] s, logic [15:0] e);
        push_tok(TK_ERROR, s, e, code);
        lx_phase = PH_ERR;
    endfunction

    function automatic void open_brace(logic [15:0] off);
        if (lx_depth < DEPTH_CAP) lx_depth++;
        push_tok(TK_LBRACE, off, off + 16'd1, ERR_NONE);
        lx_phase = PH_IDLE;
    endfunction

    // Own operator tables, kept independent of the package helpers.
    function automatic t_pend pend_lookup_tb(logic [7:0] c);
        t_pend p;
        p.hit = 1'b1;
        p.idx = 3'd0;
        case (c)
            "?": p.idx = 3'd0;
            ":": p.idx = 3'd1;
            "<": p.idx = 3'd2;
            ">": p.idx = 3'd3;
            "=": p.idx = 3'd4;
            "!": p.idx = 3'd5;
            "&": p.idx = 3'd6;
            "|": p.idx = 3'd7;
            default: p.hit = 1'b0;
        endcase
        return p;
    endfunction

    function automatic logic [5:0] single_op_tb(logic [7:0] c);
        case (c)
            "(": return TK_LPAREN;
            ")": return TK_RPAREN;
            "[": return TK_LBRACKET;
            "]": return TK_RBRACKET;
            "+": return TK_PLUS;
            "-": return TK_MINUS;
            "*": return TK_STAR;
            "/": return TK_SLASH;
            "%": return TK_PERCENT;
            "^": return TK_CARET;
            "$": return TK_DOLLAR;
            ".": return TK_DOT;
            ",": return TK_COMMA;
            default: return TK_SEGMENT;
        endcase
    endfunction

    function automatic void lex_expr_char(logic [7:0] c, logic [15:0] off);
        t_pend p;
        logic [5:0] k;
        lx_phase = PH_IDLE;
        lx_start = off;
        p = pend_lookup_tb(c);
        k = single_op_tb(c);
        if (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D) lx_phase = PH_WS;
        else if (c >= "0" && c <= "9") lx_phase = PH_INT;
        else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_")
            lx_phase = PH_IDENT;
        else if (c == "'" || c == "\"") begin
            lx_dq = (c == "\"");
            lx_start = off + 16'd1;
            lx_phase = PH_STR;
        end else if (p.hit) lx_phase = t_phase'(PH_PEND0 + p.idx);
        else if (c == "{") open_brace(off);
        else if (c == "}") begin
            if (lx_depth == 0) raise_err(ERR_RBRACE, off, off + 16'd1);
            else begin
                lx_depth--;
                push_tok(TK_RBRACE, off, off + 16'd1, ERR_NONE);
            end
        end else if (k != TK_SEGMENT) push_tok(k, off, off + 16'd1, ERR_NONE);
        else raise_err(ERR_UNKNOWN, off, off + 16'd1);
    endfunction

    function automatic void lex_idle_char(logic [7:0] c, logic [15:0] off);
        if (lx_direct || lx_depth > 0) lex_expr_char(c, off);
        else if (c == "{") open_brace(off);
        else begin
            lx_start = off;
            lx_phase = PH_TEXT;
        end
    endfunction

    function automatic void clear_lexer();
        lx_offset = '0;
        lx_depth = '0;
        lx_phase = PH_IDLE;
        lx_start = '0;
        lx_dq = 1'b0;
    endfunction

    function automatic void lex_end_of_source();
        logic [15:0] off;
        int i;
        logic [5:0] singles [8];
        logic [3:0] errs [8];
        singles = '{TK_QUESTION, TK_COLON, TK_LESS, TK_GREATER, TK_SEGMENT, TK_NOT,
                    TK_SEGMENT, TK_SEGMENT};
        errs = '{ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, ERR_EQUAL, ERR_NONE,
                 ERR_AMP, ERR_PIPE};
        off = lx_offset;
        if (lx_phase == PH_ERR) return;
        if (lx_phase == PH_STR || lx_phase == PH_STRESC) begin
            raise_err(ERR_EOS_STR, off - 16'd1, off);
            return;
        end
        if (lx_phase == PH_WS && !lx_direct) begin
            raise_err(ERR_EOS_EXPR, off - 16'd1, off);
            return;
        end
        case (lx_phase)
            PH_TEXT:  push_tok(TK_SEGMENT, lx_start, off, ERR_NONE);
            PH_INT:   push_tok(TK_INTEGER, lx_start, off, ERR_NONE);
            PH_FRAC:  push_tok(TK_FLOAT, lx_start, off, ERR_NONE);
            PH_IDENT: push_tok(TK_IDENT, lx_start, off, ERR_NONE);
            PH_INTDOT: begin
                push_tok(TK_INTEGER, lx_start, off - 16'd1, ERR_NONE);
                push_tok(TK_DOT, off - 16'd1, off, ERR_NONE);
            end
            default: begin
                if (lx_phase >= PH_PEND0 && lx_phase <= PH_PEND7) begin
                    i = lx_phase - PH_PEND0;
                    if (errs[i] != ERR_NONE) begin
                        raise_err(errs[i], lx_start, lx_start + 16'd1);
                        return;
                    end
                    push_tok(singles[i], lx_start, lx_start + 16'd1, ERR_NONE);
                end
            end
        endcase
        push_tok(TK_EOF, off, off, ERR_NONE);
    endfunction

    function automatic void lex_source_char(logic [7:0] c);
        logic [15:0] off;
        int i;
        logic [7:0] seconds [8];
        logic [5:0] singles [8];
        logic [5:0] doubles [8];
        logic [3:0] errs [8];
        logic is_dig;
        seconds = '{"?", "=", "=", "=", "=", "=", "&", "|"};
        singles = '{TK_QUESTION, TK_COLON, TK_LESS, TK_GREATER, TK_SEGMENT, TK_NOT,
                    TK_SEGMENT, TK_SEGMENT};
        doubles = '{TK_COALESCE, TK_ASSIGN, TK_LESS_EQ, TK_GREAT_EQ, TK_EQ_EQ,
                    TK_NOT_EQ, TK_AND, TK_OR};
        errs = '{ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, ERR_EQUAL, ERR_NONE,
                 ERR_AMP, ERR_PIPE};
        off = lx_offset;
        is_dig = (c >= "0" && c <= "9");
        if (lx_phase == PH_ERR) return;
        if (off == OFF_MASK) begin
            raise_err(ERR_TOO_LONG, off, off);
            return;
        end
        lx_offset = off + 16'd1;
        case (lx_phase)
            PH_IDLE, PH_WS: lex_idle_char(c, off);
            PH_TEXT: begin
                if (c == "{") begin
                    push_tok(TK_SEGMENT, lx_start, off, ERR_NONE);
                    open_brace(off);
                end
            end
            PH_STR: begin
                if (c == "\\") lx_phase = PH_STRESC;
                else if (c == (lx_dq ? "\"" : "'")) begin
                    push_tok(TK_STRING, lx_start, off, ERR_NONE);
                    lx_phase = PH_IDLE;
                end
            end
            PH_STRESC: lx_phase = PH_STR;
            PH_INT, PH_FRAC: begin
                if (is_dig) return;
                if (lx_phase == PH_INT && c == ".") begin
                    lx_phase = PH_INTDOT;
                    return;
                end
                push_tok(lx_phase == PH_INT ? TK_INTEGER : TK_FLOAT, lx_start, off,
                         ERR_NONE);
                lex_idle_char(c, off);
            end
            PH_INTDOT: begin
                if (is_dig) begin
                    lx_phase = PH_FRAC;
                    return;
                end
                push_tok(TK_INTEGER, lx_start, off - 16'd1, ERR_NONE);
                push_tok(TK_DOT, off - 16'd1, off, ERR_NONE);
                lex_idle_char(c, off);
            end
            PH_IDENT: begin
                if (is_dig || c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                    return;
                push_tok(TK_IDENT, lx_start, off, ERR_NONE);
                lex_idle_char(c, off);
            end
            default: begin
                i = lx_phase - PH_PEND0;
                if (c == seconds[i]) begin
                    push_tok(doubles[i], lx_start, off + 16'd1, ERR_NONE);
                    lx_phase = PH_IDLE;
                    return;
                end
                if (errs[i] != ERR_NONE) begin
                    raise_err(errs[i], lx_start, lx_start + 16'd1);
                    return;
                end
                push_tok(singles[i], lx_start, lx_start + 16'd1, ERR_NONE);
                lex_idle_char(c, off);
            end
        endcase
    endfunction

    // Predicts the tokens of one accepted item and queues them.
    function automatic void predict_tokens(t_src it);
        step_toks.delete();
        if (it.kind == KIND_END) begin
            lex_end_of_source();
            clear_lexer();
        end else begin
            lex_source_char(it.ch);
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) expected_toks.push_back(step_toks[i]);
    endfunction

    // Driver: bursts of transfers separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            predict_tokens(pending_src.pop_front());
        end
        if (!(i_s_tvalid && !o_s_tready)) begin
            if (drv_enable && pending_src.size() > 0 && gap_left == 0
                && !(i_s_tvalid && o_s_tready && pending_src.size() == 0)) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser <= pending_src[0].kind;
                i_s_tdata <= pending_src[0].ch;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if (burst_left == 0 && $urandom_range(0, 2) != 0)
                    gap_left = $urandom_range(1, 6);
            end else begin
                i_s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // Receiver stall pattern: alternates free-running and choppy stretches.
    int rx_phase_len = 0;
    logic rx_choppy = 1'b0;
    always @(posedge i_clk) begin
        if (rx_phase_len == 0) begin
            rx_phase_len = $urandom_range(10, 60);
            rx_choppy = $urandom_range(0, 1);
        end
        rx_phase_len--;
        i_m_tready <= rx_choppy ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // Monitor: compares each output transfer with the oldest predicted token.
    always @(posedge i_clk) begin
        t_exp_tok exp_t;
        t_exp_tok got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind = o_m_tdata[5:0];
            got.tok_start = o_m_tdata[21:6];
            got.tok_end = o_m_tdata[37:22];
            got.err = o_m_tdata[41:38];
            got.last = o_m_tlast;
            if (expected_toks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token kind=%0d start=%0d end=%0d err=%0d last=%0b",
                             got.kind, got.tok_start, got.tok_end, got.err, got.last);
            end else begin
                exp_t = expected_toks.pop_front();
                if (got !== exp_t) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("token mismatch: expected kind=%0d start=%0d end=%0d %s",
                                 exp_t.kind, exp_t.tok_start, exp_t.tok_end, "");
                        $display("    expected err=%0d last=%0b", exp_t.err, exp_t.last);
                        $display("    got kind=%0d start=%0d end=%0d err=%0d last=%0b",
                                 got.kind, got.tok_start, got.tok_end, got.err,
                                 got.last);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("template_expression_tokenizer_top_tb NOT OK");
            $finish;
        end
    end

    task automatic add_char(input logic [7:0] c);
        t_src s;
        s.kind = KIND_BYTE;
        s.ch = c;
        pending_src.push_back(s);
    endtask

    task automatic add_text(input string txt);
        foreach (txt[i]) add_char(txt[i]);
    endtask

    task automatic add_end();
        t_src s;
        s.kind = KIND_END;
        s.ch = 8'($urandom_range(0, 255));
        pending_src.push_back(s);
    endtask

    // Random well-formed template fragments, with occasional noise.
    task automatic add_random_source(input int n_items, input logic direct);
        string frags [] = '{"abc ", "{", "}", "x_1", "42", "3.14", "7.", "'a\\'b'",
                           "\"q\"", "??", "?", ":=", "<=", ">=", "==", "!=", "&&",
                           "||", "<", ">", "!", ":", "( ", ")", "[", "]", "+", "-",
                           "*", "/", "%", "^", "$", ".", ",", " ", "\t", "\n", "\r"};
        int cnt;
        string f;
        cnt = 0;
        if (!direct) begin
            add_text("hi {");
            cnt = 4;
        end
        while (cnt < n_items) begin
            if ($urandom_range(0, 19) == 0) add_char(8'($urandom_range(0, 255)));
            else begin
                f = frags[$urandom_range(0, frags.size() - 1)];
                add_text(f);
                cnt += f.len() - 1;
            end
            cnt++;
        end
        add_end();
    endtask

    task automatic wait_drained();
        while (pending_src.size() > 0 || i_s_tvalid || expected_toks.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_direct(input logic v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lx_direct = v;
    endtask

    initial begin
        int total;
        int k;
        clear_lexer();
        lx_direct = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed template sources in text mode.
        add_text("ab{x.y+1.5}c"); add_end();
        add_text("{7. 'it\\'s'\"d\"}"); add_end();
        add_text("{a ?? b<=c>=d==e!=f&&g||h:=i}"); add_end();
        add_text("{=x}"); add_end();
        add_text("}"); add_end();
        add_text("{&|"); add_end();
        add_text("{'open"); add_end();
        add_text("{x "); add_end();
        add_text("{#"); add_end();
        add_char(8'hFF); add_char(8'h00); add_end();
        drv_enable = 1'b1;
        wait_drained();

        // Direct mode with every single-character operator.
        set_direct(1'b1);
        add_text("()[]+-*/%^$.,?:<>!{}x "); add_end();
        add_text("12.5 9. \"s\" _id <"); add_end();
        wait_drained();

        // Random phases alternating both settings.
        total = 0;
        k = 0;
        while (total < 180) begin
            set_direct(k[0]);
            add_random_source(40, k[0]);
            add_random_source(20, k[0]);
            total += 60;
            k++;
            wait_drained();
        end

        if (mismatches == 0 && expected_toks.size() == 0)
            $display("template_expression_tokenizer_top_tb OK");
        else
            $display("template_expression_tokenizer_top_tb NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/tet_pkg.sv
rtl/tet_lex.sv
rtl/template_expression_tokenizer_top.sv
rtl/tet_checker.sv
bench/template_expression_tokenizer_top_tb.sv
